@@ rtl/core/rch_pkg.sv @@
// Shared widths, constants and types for the ray/capsule hit test.
package rch_pkg;

	localparam int P_W    = 32;
	localparam int CFG_W  = 31;
	localparam int T_W    = 31;
	localparam int A_W    = 64;
	localparam int B_W    = 68;
	localparam int C_W    = 72;
	localparam int DISC_W = 136;
	localparam int ROOT_W = DISC_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int N_W    = ROOT_W + 2;
	localparam int NUM_W  = N_W + 16;
	localparam int DIV_W  = A_W + T_W;
	localparam int L_ROOT = 6 + ROOT_W + T_W;

	localparam logic [T_W-1:0]   CUTOFF     = 31'h7FFF_FFFF;
	localparam logic [CFG_W-1:0] RADIUS_RST = 31'd32768;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 31'd131072;

	localparam logic CFG_RADIUS = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic           ok;
		logic [T_W-1:0] t;
	} root_res_t;

endpackage

@@ rtl/core/ray_capsule_hit_test.sv @@
// One ray accepted every cycle.
// The depth is set by the four-stage wide multiply, the one-bit-a-stage square
// root (68 stages) and the one-bit-a-stage divider (31 stages) in each of the
// three root solvers.
// busy is always low; done pulses for one cycle with hit and distance.
// Reset clears all valid bits and loads radius 0.5 and height 2.0.
module ray_capsule_hit_test (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [rch_pkg::P_W-1:0]  origin_x,
	input  logic signed [rch_pkg::P_W-1:0]  origin_y,
	input  logic signed [rch_pkg::P_W-1:0]  origin_z,
	input  logic signed [rch_pkg::P_W-1:0]  dir_x,
	input  logic signed [rch_pkg::P_W-1:0]  dir_y,
	input  logic signed [rch_pkg::P_W-1:0]  dir_z,
	input  logic signed [rch_pkg::P_W-1:0]  pos_x,
	input  logic signed [rch_pkg::P_W-1:0]  pos_y,
	input  logic signed [rch_pkg::P_W-1:0]  pos_z,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [rch_pkg::CFG_W-1:0]       cfg_data,
	output logic                            done,
	output logic                            hit,
	output logic [rch_pkg::T_W-1:0]         distance
);
	import rch_pkg::*;

	logic [CFG_W-1:0] radius_q;
	logic [CFG_W-1:0] height_q;

	logic               v_s1;
	logic signed [32:0] ox_s1, oz_s1, span_s1;
	logic signed [34:0] oyl_s1, oyu_s1;
	logic signed [31:0] dx_s1, dy_s1, dz_s1;
	logic [CFG_W-1:0]   r_s1;

	logic               v_s2;
	logic [63:0]        dxx_s2, dyy_s2, dzz_s2;
	logic signed [64:0] oxdx_s2, ozdz_s2;
	logic signed [66:0] oyldy_s2, oyudy_s2;
	logic signed [65:0] oxx_s2, ozz_s2;
	logic signed [69:0] oyll_s2, oyuu_s2;
	logic [61:0]        rr_s2;
	logic signed [34:0] oyl_s2;
	logic signed [31:0] dy_s2;
	logic signed [32:0] span_s2;

	logic                  v_s3;
	logic [A_W-1:0]        as_s3, ac_s3;
	logic signed [B_W-1:0] bl_s3, bu_s3, bc_s3;
	logic signed [C_W-1:0] cl_s3, cu_s3, cc_s3;
	logic signed [34:0]    oyl_s3;
	logic signed [31:0]    dy_s3;
	logic signed [32:0]    span_s3;

	logic signed [34:0] dl_oyl  [L_ROOT];
	logic signed [31:0] dl_dy   [L_ROOT];
	logic signed [32:0] dl_span [L_ROOT];

	logic      vl, vc, vu;
	root_res_t rl, rc, ru;

	logic               v_s4;
	root_res_t          rl_s4, rc_s4, ru_s4;
	logic signed [63:0] ydt_s4;
	logic signed [34:0] oyl_s4;
	logic signed [32:0] span_s4;

	logic signed [65:0] y_w;
	logic signed [65:0] ylim_w;
	logic               cyl_ok;
	logic [T_W-1:0]     best;
	logic               any;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RADIUS: radius_q <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= vl && vc && vu;
			done <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ox_s1   <= 33'(origin_x) - 33'(pos_x);
		oz_s1   <= 33'(origin_z) - 33'(pos_z);
		oyl_s1  <= 35'(origin_y) - 35'(pos_y) - 35'(radius_q);
		oyu_s1  <= 35'(origin_y) - 35'(pos_y) - 35'(height_q) + 35'(radius_q);
		span_s1 <= 33'(height_q) - {1'b0, radius_q, 1'b0};
		dx_s1   <= dir_x;
		dy_s1   <= dir_y;
		dz_s1   <= dir_z;
		r_s1    <= radius_q;
	end

	always_ff @(posedge clk) begin
		dxx_s2   <= 64'(dx_s1) * 64'(dx_s1);
		dyy_s2   <= 64'(dy_s1) * 64'(dy_s1);
		dzz_s2   <= 64'(dz_s1) * 64'(dz_s1);
		oxdx_s2  <= 65'(ox_s1) * 65'(dx_s1);
		ozdz_s2  <= 65'(oz_s1) * 65'(dz_s1);
		oyldy_s2 <= 67'(oyl_s1) * 67'(dy_s1);
		oyudy_s2 <= 67'(oyu_s1) * 67'(dy_s1);
		oxx_s2   <= 66'(ox_s1) * 66'(ox_s1);
		ozz_s2   <= 66'(oz_s1) * 66'(oz_s1);
		oyll_s2  <= 70'(oyl_s1) * 70'(oyl_s1);
		oyuu_s2  <= 70'(oyu_s1) * 70'(oyu_s1);
		rr_s2    <= 62'(r_s1) * 62'(r_s1);
		oyl_s2   <= oyl_s1;
		dy_s2    <= dy_s1;
		span_s2  <= span_s1;
	end

	always_ff @(posedge clk) begin
		as_s3   <= dxx_s2 + dyy_s2 + dzz_s2;
		ac_s3   <= dxx_s2 + dzz_s2;
		bl_s3   <= B_W'(oxdx_s2) + B_W'(oyldy_s2) + B_W'(ozdz_s2);
		bu_s3   <= B_W'(oxdx_s2) + B_W'(oyudy_s2) + B_W'(ozdz_s2);
		bc_s3   <= B_W'(oxdx_s2) + B_W'(ozdz_s2);
		cl_s3   <= C_W'(oxx_s2) + C_W'(oyll_s2) + C_W'(ozz_s2) - signed'(C_W'(rr_s2));
		cu_s3   <= C_W'(oxx_s2) + C_W'(oyuu_s2) + C_W'(ozz_s2) - signed'(C_W'(rr_s2));
		cc_s3   <= C_W'(oxx_s2) + C_W'(ozz_s2) - signed'(C_W'(rr_s2));
		oyl_s3  <= oyl_s2;
		dy_s3   <= dy_s2;
		span_s3 <= span_s2;
	end

	always_ff @(posedge clk) begin
		dl_oyl[0]  <= oyl_s3;
		dl_dy[0]   <= dy_s3;
		dl_span[0] <= span_s3;
		for (int i = 1; i < L_ROOT; i++) begin
			dl_oyl[i]  <= dl_oyl[i-1];
			dl_dy[i]   <= dl_dy[i-1];
			dl_span[i] <= dl_span[i-1];
		end
	end

	rch_root u_low (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.a         (as_s3),
		.b         (bl_s3),
		.c         (cl_s3),
		.out_valid (vl),
		.res       (rl)
	);

	rch_root u_cyl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.a         (ac_s3),
		.b         (bc_s3),
		.c         (cc_s3),
		.out_valid (vc),
		.res       (rc)
	);

	rch_root u_up (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.a         (as_s3),
		.b         (bu_s3),
		.c         (cu_s3),
		.out_valid (vu),
		.res       (ru)
	);

	always_ff @(posedge clk) begin
		rl_s4   <= rl;
		rc_s4   <= rc;
		ru_s4   <= ru;
		ydt_s4  <= 64'(signed'({1'b0, rc.t})) * 64'(dl_dy[L_ROOT-1]);
		oyl_s4  <= dl_oyl[L_ROOT-1];
		span_s4 <= dl_span[L_ROOT-1];
	end

	assign y_w    = {{15{oyl_s4[34]}}, oyl_s4, 16'h0000} + 66'(ydt_s4);
	assign ylim_w = {{17{span_s4[32]}}, span_s4, 16'h0000};
	assign cyl_ok = rc_s4.ok && !y_w[65] && (y_w <= ylim_w);

	always_comb begin
		best = CUTOFF;
		any  = 1'b0;
		if (rl_s4.ok) begin
			best = rl_s4.t;
			any  = 1'b1;
		end
		if (cyl_ok && (rc_s4.t < best)) begin
			best = rc_s4.t;
			any  = 1'b1;
		end
		if (ru_s4.ok && (ru_s4.t < best)) begin
			best = ru_s4.t;
			any  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		hit      <= any;
		distance <= any ? best : '0;
	end

endmodule

@@ rtl/core/rch_root.sv @@
// Pipelined nearer-root solver: discriminant, square root and division.
module rch_root (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [rch_pkg::A_W-1:0]         a,
	input  logic signed [rch_pkg::B_W-1:0]  b,
	input  logic signed [rch_pkg::C_W-1:0]  c,
	output logic                            out_valid,
	output rch_pkg::root_res_t              res
);
	import rch_pkg::*;

	localparam int BB_W  = 2 * B_W;
	localparam int AC_W  = A_W + C_W + 1;
	localparam int DF_W  = AC_W + 1;
	localparam int LW    = 32;
	localparam int PP_W  = 2 * LW;
	localparam int COL_W = PP_W + 2;
	localparam int BM_W  = 3 * LW;

	logic                   v_s1, v_s2, v_s3, v_s4;
	logic [A_W-1:0]         a_s1, a_s2, a_s3, a_s4;
	logic signed [B_W-1:0]  b_s1, b_s2, b_s3, b_s4;
	logic                   cneg_s1, cneg_s2, cneg_s3, cneg_s4;
	logic [BM_W-1:0]        bm_s1, cm_s1;
	logic [PP_W-1:0]        b00_s2, b01_s2, b02_s2, b11_s2, b12_s2, b22_s2;
	logic [PP_W-1:0]        q00_s2, q01_s2, q02_s2, q10_s2, q11_s2, q12_s2;
	logic [COL_W-1:0]       bc0_s3, bc1_s3, bc2_s3, bc3_s3, bc4_s3;
	logic [COL_W-1:0]       ac0_s3, ac1_s3, ac2_s3, ac3_s3;
	logic [BB_W-1:0]        bb_s4;
	logic [AC_W-1:0]        acm_s4;
	logic signed [DF_W-1:0] disc_w;

	logic                   sq_v    [ROOT_W+1];
	logic                   sq_ok   [ROOT_W+1];
	logic [A_W-1:0]         sq_a    [ROOT_W+1];
	logic signed [B_W-1:0]  sq_b    [ROOT_W+1];
	logic [REM_W-1:0]       sq_rem  [ROOT_W+1];
	logic [ROOT_W-1:0]      sq_root [ROOT_W+1];
	logic [DISC_W-1:0]      sq_rad  [ROOT_W+1];

	logic signed [N_W-1:0]  n_w;
	logic [NUM_W-1:0]       num_w;
	logic [DIV_W-1:0]       lim_w;

	logic                   dv_v   [T_W+1];
	logic                   dv_ok  [T_W+1];
	logic [A_W-1:0]         dv_a   [T_W+1];
	logic [DIV_W-1:0]       dv_rem [T_W+1];
	logic [T_W-1:0]         dv_q   [T_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			sq_v[0]  <= 1'b0;
			dv_v[0]  <= 1'b0;
		end else begin
			v_s1     <= in_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			sq_v[0]  <= v_s4;
			dv_v[0]  <= sq_v[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= a;
		b_s1    <= b;
		bm_s1   <= BM_W'(b[B_W-1] ? -b : b);
		cm_s1   <= BM_W'(c[C_W-1] ? -c : c);
		cneg_s1 <= c[C_W-1];
	end

	always_ff @(posedge clk) begin
		a_s2    <= a_s1;
		b_s2    <= b_s1;
		cneg_s2 <= cneg_s1;
		b00_s2  <= PP_W'(bm_s1[0 +: LW]) * PP_W'(bm_s1[0 +: LW]);
		b01_s2  <= PP_W'(bm_s1[0 +: LW]) * PP_W'(bm_s1[LW +: LW]);
		b02_s2  <= PP_W'(bm_s1[0 +: LW]) * PP_W'(bm_s1[2*LW +: LW]);
		b11_s2  <= PP_W'(bm_s1[LW +: LW]) * PP_W'(bm_s1[LW +: LW]);
		b12_s2  <= PP_W'(bm_s1[LW +: LW]) * PP_W'(bm_s1[2*LW +: LW]);
		b22_s2  <= PP_W'(bm_s1[2*LW +: LW]) * PP_W'(bm_s1[2*LW +: LW]);
		q00_s2  <= PP_W'(a_s1[0 +: LW]) * PP_W'(cm_s1[0 +: LW]);
		q01_s2  <= PP_W'(a_s1[0 +: LW]) * PP_W'(cm_s1[LW +: LW]);
		q02_s2  <= PP_W'(a_s1[0 +: LW]) * PP_W'(cm_s1[2*LW +: LW]);
		q10_s2  <= PP_W'(a_s1[LW +: LW]) * PP_W'(cm_s1[0 +: LW]);
		q11_s2  <= PP_W'(a_s1[LW +: LW]) * PP_W'(cm_s1[LW +: LW]);
		q12_s2  <= PP_W'(a_s1[LW +: LW]) * PP_W'(cm_s1[2*LW +: LW]);
	end

	always_ff @(posedge clk) begin
		a_s3    <= a_s2;
		b_s3    <= b_s2;
		cneg_s3 <= cneg_s2;
		bc0_s3  <= COL_W'(b00_s2);
		bc1_s3  <= COL_W'({b01_s2, 1'b0});
		bc2_s3  <= COL_W'({b02_s2, 1'b0}) + COL_W'(b11_s2);
		bc3_s3  <= COL_W'({b12_s2, 1'b0});
		bc4_s3  <= COL_W'(b22_s2);
		ac0_s3  <= COL_W'(q00_s2);
		ac1_s3  <= COL_W'(q01_s2) + COL_W'(q10_s2);
		ac2_s3  <= COL_W'(q02_s2) + COL_W'(q11_s2);
		ac3_s3  <= COL_W'(q12_s2);
	end

	always_ff @(posedge clk) begin
		a_s4    <= a_s3;
		b_s4    <= b_s3;
		cneg_s4 <= cneg_s3;
		bb_s4   <= BB_W'(bc0_s3) + (BB_W'(bc1_s3) << LW) + (BB_W'(bc2_s3) << (2 * LW))
		         + (BB_W'(bc3_s3) << (3 * LW)) + (BB_W'(bc4_s3) << (4 * LW));
		acm_s4  <= AC_W'(ac0_s3) + (AC_W'(ac1_s3) << LW) + (AC_W'(ac2_s3) << (2 * LW))
		         + (AC_W'(ac3_s3) << (3 * LW));
	end

	assign disc_w = cneg_s4 ? DF_W'(bb_s4) + DF_W'(acm_s4) : DF_W'(bb_s4) - DF_W'(acm_s4);

	always_ff @(posedge clk) begin
		sq_ok[0]   <= !disc_w[DF_W-1] && (a_s4 != '0);
		sq_a[0]    <= a_s4;
		sq_b[0]    <= b_s4;
		sq_rem[0]  <= '0;
		sq_root[0] <= '0;
		sq_rad[0]  <= disc_w[DISC_W-1:0];
	end

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
		logic [REM_W+1:0] cat;
		logic [REM_W+1:0] trial;
		logic             ge;

		assign cat   = {sq_rem[k-1], sq_rad[k-1][DISC_W-1 -: 2]};
		assign trial = {2'b00, sq_root[k-1], 2'b01};
		assign ge    = cat >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k] <= 1'b0;
			end else begin
				sq_v[k] <= sq_v[k-1];
			end
		end

		always_ff @(posedge clk) begin
			sq_ok[k]   <= sq_ok[k-1];
			sq_a[k]    <= sq_a[k-1];
			sq_b[k]    <= sq_b[k-1];
			sq_rem[k]  <= ge ? REM_W'(cat - trial) : REM_W'(cat);
			sq_root[k] <= {sq_root[k-1][ROOT_W-2:0], ge};
			sq_rad[k]  <= sq_rad[k-1] << 2;
		end
	end

	assign n_w   = -N_W'(sq_b[ROOT_W]) - signed'(N_W'(sq_root[ROOT_W]));
	assign num_w = {n_w, 16'h0000};
	assign lim_w = {sq_a[ROOT_W], {T_W{1'b0}}} - DIV_W'(sq_a[ROOT_W]);

	always_ff @(posedge clk) begin
		dv_ok[0]  <= sq_ok[ROOT_W] && (n_w > 0) && (DIV_W'(num_w) < lim_w);
		dv_a[0]   <= sq_a[ROOT_W];
		dv_rem[0] <= DIV_W'(num_w);
		dv_q[0]   <= '0;
	end

	for (genvar k = 1; k <= T_W; k++) begin : g_div
		logic [DIV_W-1:0] shf;
		logic             ge;

		assign shf = DIV_W'(dv_a[k-1]) << (T_W - k);
		assign ge  = dv_rem[k-1] >= shf;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k] <= 1'b0;
			end else begin
				dv_v[k] <= dv_v[k-1];
			end
		end

		always_ff @(posedge clk) begin
			dv_ok[k]  <= dv_ok[k-1];
			dv_a[k]   <= dv_a[k-1];
			dv_rem[k] <= ge ? dv_rem[k-1] - shf : dv_rem[k-1];
			dv_q[k]   <= {dv_q[k-1][T_W-2:0], ge};
		end
	end

	assign out_valid = dv_v[T_W];
	assign res.ok    = dv_ok[T_W] && (dv_q[T_W] != '0);
	assign res.t     = dv_q[T_W];

endmodule
